@@ rtl/rtst_pkg.sv @@
`timescale 1ns / 1ps

package rtst_pkg;

  // field widths of the transfer channels
  localparam int unsigned TagW    = 16;
  localparam int unsigned StampW  = 48;
  localparam int unsigned TotalW  = 64;
  localparam int unsigned CallsW  = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 3;

  // depth of the queue between front and back (power of two)
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [OpW-1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_RUNNING     = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_FULL        = 3'd3,
    ST_NOT_RUNNING = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_INDEX,
    BK_ENTRY,
    BK_UPDATE
  } back_state_e;

  // one queued operation
  typedef struct packed {
    op_e               op;
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] stamp;
  } item_t;

endpackage

@@ rtl/region_timing_statistics_table_core.sv @@
`timescale 1ns / 1ps
// An item passes from the input queue through the tag-map read, entry read, hit check with
// interval compute, and entry update to the output register; the back end works on one item
// at a time, and the tag-map read of the next item overlaps the update. A stalled result
// holds the back end until it is taken.
// Reset: asynchronous, active low; clears the queue, sequencer, output valid and the
// fill count, so the table is empty at once with no clearing pass over the RAMs.

module region_timing_statistics_table_core #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rtst_pkg::OpW-1:0]     op_i,
  input  logic [rtst_pkg::TagW-1:0]    tag_i,
  input  logic [rtst_pkg::StampW-1:0]  time_stamp_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rtst_pkg::StatusW-1:0] status_o,
  output logic [rtst_pkg::TotalW-1:0]  total_time_o,
  output logic [rtst_pkg::CallsW-1:0]  call_count_o,
  output logic [rtst_pkg::StampW-1:0]  min_time_o,
  output logic [rtst_pkg::StampW-1:0]  max_time_o,
  output logic [rtst_pkg::StampW-1:0]  last_interval_o
);

  logic            q_valid;
  logic            q_pop;
  rtst_pkg::item_t q_item;

  // input side: decode and queue
  rtst_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .tag_i        (tag_i),
    .time_stamp_i (time_stamp_i),
    .q_valid_o    (q_valid),
    .q_pop_i      (q_pop),
    .q_item_o     (q_item)
  );

  // table side: lookup, update, result register
  rtst_back #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_item_i        (q_item),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .total_time_o    (total_time_o),
    .call_count_o    (call_count_o),
    .min_time_o      (min_time_o),
    .max_time_o      (max_time_o),
    .last_interval_o (last_interval_o)
  );

endmodule

@@ rtl/rtst_front.sv @@
`timescale 1ns / 1ps

module rtst_front #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rtst_pkg::OpW-1:0]           op_i,
  input  logic [rtst_pkg::TagW-1:0]          tag_i,
  input  logic [rtst_pkg::StampW-1:0]        time_stamp_i,
  output logic                               q_valid_o,
  input  logic                               q_pop_i,
  output rtst_pkg::item_t                    q_item_o
);

  localparam int unsigned TW   = (TIME_BITS < rtst_pkg::StampW) ? TIME_BITS : rtst_pkg::StampW;
  localparam int unsigned PtrW = $clog2(rtst_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(rtst_pkg::QueueDepth + 1);
  localparam logic [rtst_pkg::StampW-1:0] StampMask =
    (TW >= rtst_pkg::StampW) ? {rtst_pkg::StampW{1'b1}}
                             : ((rtst_pkg::StampW'(1) << TW) - rtst_pkg::StampW'(1));

  rtst_pkg::item_t fifo_q [rtst_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  rtst_pkg::item_t item_in;

  // classify the incoming operation and trim the timestamp to the counter width
  always_comb begin
    item_in.op    = rtst_pkg::op_e'(op_i);
    item_in.tag   = tag_i;
    item_in.stamp = time_stamp_i & StampMask;
  end

  assign in_stall_o = (cnt_q == CntW'(rtst_pkg::QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = fifo_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ rtl/rtst_back.sv @@
`timescale 1ns / 1ps

module rtst_back #(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  rtst_pkg::item_t              q_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rtst_pkg::StatusW-1:0] status_o,
  output logic [rtst_pkg::TotalW-1:0]  total_time_o,
  output logic [rtst_pkg::CallsW-1:0]  call_count_o,
  output logic [rtst_pkg::StampW-1:0]  min_time_o,
  output logic [rtst_pkg::StampW-1:0]  max_time_o,
  output logic [rtst_pkg::StampW-1:0]  last_interval_o
);

  localparam int unsigned TW       = TIME_BITS;
  localparam int unsigned IdxW     = $clog2(ENTRIES);
  localparam int unsigned UsedW    = $clog2(ENTRIES + 1);
  localparam int unsigned SumW     = rtst_pkg::TotalW + 1;
  localparam int unsigned TagDepth = 2 ** rtst_pkg::TagW;

  // tag to entry map and the entry table
  logic [IdxW-1:0]                idx_mem       [TagDepth];
  logic [rtst_pkg::TagW-1:0]      ent_tag_mem   [ENTRIES];
  logic                           ent_run_mem   [ENTRIES];
  logic [TW-1:0]                  ent_start_mem [ENTRIES];
  logic [rtst_pkg::TotalW-1:0]    ent_total_mem [ENTRIES];
  logic [rtst_pkg::CallsW-1:0]    ent_calls_mem [ENTRIES];
  logic [TW-1:0]                  ent_min_mem   [ENTRIES];
  logic [TW-1:0]                  ent_max_mem   [ENTRIES];

  rtst_pkg::back_state_e state_q, state_d;
  rtst_pkg::item_t       item_q;
  logic [UsedW-1:0]      used_q, used_d;
  logic [IdxW-1:0]       cand_q;

  logic [rtst_pkg::TagW-1:0]   ent_tag_q;
  logic                        ent_run_q;
  logic [TW-1:0]               ent_start_q;
  logic [rtst_pkg::TotalW-1:0] ent_total_q;
  logic [rtst_pkg::CallsW-1:0] ent_calls_q;
  logic [TW-1:0]               ent_min_q;
  logic [TW-1:0]               ent_max_q;

  logic          hit_q, hit_d;
  logic [TW-1:0] iv_q, iv_d;
  logic [TW-1:0] stamp_tw;

  logic fire;

  // entry write port
  logic                        ent_we;
  logic [IdxW-1:0]             ent_waddr;
  logic                        new_run;
  logic [TW-1:0]               new_start;
  logic [rtst_pkg::TotalW-1:0] new_total;
  logic [rtst_pkg::CallsW-1:0] new_calls;
  logic [TW-1:0]               new_min;
  logic [TW-1:0]               new_max;
  logic                        idx_we;
  logic [SumW-1:0]             sum;

  // result
  logic                        out_valid_q;
  rtst_pkg::status_e           res_status, status_q;
  logic [rtst_pkg::TotalW-1:0] res_total, total_q;
  logic [rtst_pkg::CallsW-1:0] res_calls, calls_q;
  logic [rtst_pkg::StampW-1:0] res_min, min_q;
  logic [rtst_pkg::StampW-1:0] res_max, max_q;
  logic [rtst_pkg::StampW-1:0] res_last, last_q;

  // sequencer: map lookup, entry read, interval, update
  always_comb begin
    fire    = (state_q == rtst_pkg::BK_UPDATE) && (!out_valid_q || !out_stall_i);
    q_pop_o = q_valid_i && ((state_q == rtst_pkg::BK_IDLE) || fire);
    state_d = state_q;
    case (state_q)
      rtst_pkg::BK_IDLE: begin
        if (q_pop_o) begin
          state_d = rtst_pkg::BK_INDEX;
        end
      end
      rtst_pkg::BK_INDEX: begin
        state_d = rtst_pkg::BK_ENTRY;
      end
      rtst_pkg::BK_ENTRY: begin
        state_d = rtst_pkg::BK_UPDATE;
      end
      rtst_pkg::BK_UPDATE: begin
        if (fire) begin
          state_d = q_pop_o ? rtst_pkg::BK_INDEX : rtst_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = rtst_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtst_pkg::BK_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  // current operation
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
  end

  // timestamp at the interval width, zero above the port width
  assign stamp_tw = TW'(item_q.stamp);

  // tag map: read on pop, forward an allocation written at the same edge
  always_ff @(posedge clk_i) begin
    if (idx_we) begin
      idx_mem[item_q.tag] <= used_q[IdxW-1:0];
    end
    if (q_pop_o) begin
      if (idx_we && (q_item_i.tag == item_q.tag)) begin
        cand_q <= used_q[IdxW-1:0];
      end else begin
        cand_q <= idx_mem[q_item_i.tag];
      end
    end
  end

  // entry table
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_tag_mem[ent_waddr]   <= item_q.tag;
      ent_run_mem[ent_waddr]   <= new_run;
      ent_start_mem[ent_waddr] <= new_start;
      ent_total_mem[ent_waddr] <= new_total;
      ent_calls_mem[ent_waddr] <= new_calls;
      ent_min_mem[ent_waddr]   <= new_min;
      ent_max_mem[ent_waddr]   <= new_max;
    end
    if (state_q == rtst_pkg::BK_INDEX) begin
      ent_tag_q   <= ent_tag_mem[cand_q];
      ent_run_q   <= ent_run_mem[cand_q];
      ent_start_q <= ent_start_mem[cand_q];
      ent_total_q <= ent_total_mem[cand_q];
      ent_calls_q <= ent_calls_mem[cand_q];
      ent_min_q   <= ent_min_mem[cand_q];
      ent_max_q   <= ent_max_mem[cand_q];
    end
  end

  // hit check (entries below the fill count are live) and elapsed ticks
  always_comb begin
    hit_d = 1'b0;
    if (UsedW'(cand_q) < used_q) begin
      if (ent_tag_q == item_q.tag) begin
        hit_d = 1'b1;
      end
    end
    iv_d = stamp_tw - ent_start_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rtst_pkg::BK_ENTRY) begin
      hit_q <= hit_d;
      iv_q  <= iv_d;
    end
  end

  // operation decode and entry update
  always_comb begin
    ent_we     = 1'b0;
    idx_we     = 1'b0;
    ent_waddr  = cand_q;
    used_d     = used_q;
    new_run    = ent_run_q;
    new_start  = ent_start_q;
    new_total  = ent_total_q;
    new_calls  = ent_calls_q;
    new_min    = ent_min_q;
    new_max    = ent_max_q;
    sum        = {1'b0, ent_total_q} + SumW'(iv_q);
    res_status = rtst_pkg::ST_OK;
    res_total  = '0;
    res_calls  = '0;
    res_min    = '0;
    res_max    = '0;
    res_last   = '0;
    case (item_q.op)
      rtst_pkg::OP_CLEAR: begin
        used_d = '0;
      end
      rtst_pkg::OP_BEGIN: begin
        if (hit_q) begin
          res_total = ent_total_q;
          res_calls = ent_calls_q;
          res_min   = rtst_pkg::StampW'(ent_min_q);
          res_max   = rtst_pkg::StampW'(ent_max_q);
          if (ent_run_q) begin
            res_status = rtst_pkg::ST_RUNNING;
          end else begin
            ent_we    = 1'b1;
            new_run   = 1'b1;
            new_start = stamp_tw;
          end
        end else if (used_q == UsedW'(ENTRIES)) begin
          res_status = rtst_pkg::ST_FULL;
        end else begin
          // fresh entry at the fill count
          ent_we    = 1'b1;
          idx_we    = 1'b1;
          ent_waddr = used_q[IdxW-1:0];
          used_d    = used_q + UsedW'(1);
          new_run   = 1'b1;
          new_start = stamp_tw;
          new_total = '0;
          new_calls = '0;
          new_min   = '1;
          new_max   = '0;
          res_min   = rtst_pkg::StampW'(new_min);
        end
      end
      rtst_pkg::OP_END: begin
        if (!hit_q) begin
          res_status = rtst_pkg::ST_NOT_FOUND;
        end else if (!ent_run_q) begin
          res_status = rtst_pkg::ST_NOT_RUNNING;
          res_total  = ent_total_q;
          res_calls  = ent_calls_q;
          res_min    = rtst_pkg::StampW'(ent_min_q);
          res_max    = rtst_pkg::StampW'(ent_max_q);
        end else begin
          ent_we    = 1'b1;
          new_run   = 1'b0;
          new_total = sum[SumW-1] ? '1 : sum[rtst_pkg::TotalW-1:0];
          new_calls = (ent_calls_q == '1) ? ent_calls_q : ent_calls_q + rtst_pkg::CallsW'(1);
          new_min   = (iv_q < ent_min_q) ? iv_q : ent_min_q;
          new_max   = (iv_q > ent_max_q) ? iv_q : ent_max_q;
          res_total = new_total;
          res_calls = new_calls;
          res_min   = rtst_pkg::StampW'(new_min);
          res_max   = rtst_pkg::StampW'(new_max);
          res_last  = rtst_pkg::StampW'(iv_q);
        end
      end
      rtst_pkg::OP_READ: begin
        if (hit_q) begin
          res_total = ent_total_q;
          res_calls = ent_calls_q;
          res_min   = rtst_pkg::StampW'(ent_min_q);
          res_max   = rtst_pkg::StampW'(ent_max_q);
        end else begin
          res_status = rtst_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        res_status = rtst_pkg::ST_OK;
      end
    endcase
    // nothing commits until the result can be taken
    if (!fire) begin
      ent_we = 1'b0;
      idx_we = 1'b0;
      used_d = used_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= res_status;
      total_q  <= res_total;
      calls_q  <= res_calls;
      min_q    <= res_min;
      max_q    <= res_max;
      last_q   <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign total_time_o    = total_q;
  assign call_count_o    = calls_q;
  assign min_time_o      = min_q;
  assign max_time_o      = max_q;
  assign last_interval_o = last_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rtst_pkg::*;

  localparam int Slots      = 64;
  localparam int ItemCount  = 1550;
  localparam int CycleLimit = 500000;

  // expected or observed contents of one result transfer
  typedef struct packed {
    status_e           status;
    logic [TotalW-1:0] total;
    logic [CallsW-1:0] calls;
    logic [StampW-1:0] min_iv;
    logic [StampW-1:0] max_iv;
    logic [StampW-1:0] last_iv;
  } stats_t;

  // region table predictor plus queue of statistics still owed by the block
  class stats_scoreboard;
    logic              slot_valid   [Slots];
    logic              slot_running [Slots];
    logic [TagW-1:0]   slot_tag     [Slots];
    logic [StampW-1:0] slot_start   [Slots];
    logic [TotalW-1:0] slot_total   [Slots];
    logic [CallsW-1:0] slot_calls   [Slots];
    logic [StampW-1:0] slot_min     [Slots];
    logic [StampW-1:0] slot_max     [Slots];
    int                used;
    stats_t            owed_q [$];
    int                errors;
    int                n_op [4];
    int                n_status [5];
    int                n_wrap;

    function new();
      for (int i = 0; i < Slots; i++) begin
        slot_valid[i]   = 1'b0;
        slot_running[i] = 1'b0;
      end
      foreach (n_op[i]) n_op[i] = 0;
      foreach (n_status[i]) n_status[i] = 0;
      used   = 0;
      errors = 0;
      n_wrap = 0;
    endfunction

    function int lookup(logic [TagW-1:0] tag);
      for (int i = 0; i < Slots; i++) begin
        if (slot_valid[i] && slot_tag[i] == tag) return i;
      end
      return -1;
    endfunction

    function stats_t slot_stats(int idx, status_e st, logic [StampW-1:0] iv);
      stats_t r;
      r         = '0;
      r.status  = st;
      r.total   = slot_total[idx];
      r.calls   = slot_calls[idx];
      r.min_iv  = slot_min[idx];
      r.max_iv  = slot_max[idx];
      r.last_iv = iv;
      return r;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // update the table for one accepted transfer and queue its statistics
    function void note_item(op_e op, logic [TagW-1:0] tag, logic [StampW-1:0] stamp);
      stats_t            r;
      int                idx;
      logic [StampW-1:0] iv;
      logic [TotalW:0]   sum;
      r        = '0;
      r.status = ST_OK;
      n_op[op]++;
      if (op == OP_CLEAR) begin
        for (int i = 0; i < Slots; i++) begin
          slot_valid[i]   = 1'b0;
          slot_running[i] = 1'b0;
        end
        used = 0;
      end else begin
        idx = lookup(tag);
        if (op == OP_BEGIN) begin
          if (idx < 0 && used >= Slots) begin
            r.status = ST_FULL;
          end else begin
            // fresh entry on a miss, allocated in index order
            if (idx < 0) begin
              idx               = used;
              used++;
              slot_valid[idx]   = 1'b1;
              slot_tag[idx]     = tag;
              slot_total[idx]   = '0;
              slot_calls[idx]   = '0;
              slot_min[idx]     = '1;
              slot_max[idx]     = '0;
              slot_running[idx] = 1'b0;
            end
            if (slot_running[idx]) begin
              r = slot_stats(idx, ST_RUNNING, '0);
            end else begin
              slot_running[idx] = 1'b1;
              slot_start[idx]   = stamp;
              r = slot_stats(idx, ST_OK, '0);
            end
          end
        end else if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (op == OP_READ) begin
          r = slot_stats(idx, ST_OK, '0);
        end else if (!slot_running[idx]) begin
          r = slot_stats(idx, ST_NOT_RUNNING, '0);
        end else begin
          // interval wraps modulo the stamp width, total and count saturate
          iv = stamp - slot_start[idx];
          if (stamp < slot_start[idx]) n_wrap++;
          sum = {1'b0, slot_total[idx]} + iv;
          slot_total[idx] = sum[TotalW] ? '1 : sum[TotalW-1:0];
          if (slot_calls[idx] != '1) slot_calls[idx]++;
          if (iv > slot_max[idx]) slot_max[idx] = iv;
          if (iv < slot_min[idx]) slot_min[idx] = iv;
          slot_running[idx] = 1'b0;
          r = slot_stats(idx, ST_OK, iv);
        end
      end
      n_status[r.status]++;
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(stats_t got);
      stats_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result transfer, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("total_time", want.total, got.total);
      compare_field("call_count", 64'(want.calls), 64'(got.calls));
      compare_field("min_time", 64'(want.min_iv), 64'(got.min_iv));
      compare_field("max_time", 64'(want.max_iv), 64'(got.max_iv));
      compare_field("last_interval", 64'(want.last_iv), 64'(got.last_iv));
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  op_e               op_q      = OP_BEGIN;
  logic [TagW-1:0]   tag_q     = '0;
  logic [StampW-1:0] stamp_q   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [TotalW-1:0] total_time;
  logic [CallsW-1:0] call_count;
  logic [StampW-1:0] min_time;
  logic [StampW-1:0] max_time;
  logic [StampW-1:0] last_interval;

  stats_scoreboard   sb;
  int                cycle_cnt  = 0;
  int                sent       = 0;
  int                burst_left = 0;
  logic [TagW-1:0]   pool [32];
  logic [TagW-1:0]   open_q [$];
  logic [StampW-1:0] now_ts;

  region_timing_statistics_table_core #(
    .ENTRIES  (Slots),
    .TIME_BITS(StampW)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op_q),
    .tag_i          (tag_q),
    .time_stamp_i   (stamp_q),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .total_time_o   (total_time),
    .call_count_o   (call_count),
    .min_time_o     (min_time),
    .max_time_o     (max_time),
    .last_interval_o(last_interval)
  );

  // clock and cycle counter
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // watchdog
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("%0t: timeout, %0d results still owed", $time, sb.pending());
    $display("simulation failed");
    $finish;
  end

  // receiver stalls, in one of four patterns that change from span to span
  initial begin
    int mode;
    int span;
    int period;
    int phase_cnt;
    phase_cnt = 0;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(50, 300);
      period = $urandom_range(2, 16);
      repeat (span) begin
        @(negedge clk);
        phase_cnt++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((phase_cnt % period) < (period / 2));
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_result('{status_e'(status), total_time, call_count, min_time, max_time,
                        last_interval});
    end
  end

  // sender bursts: random length, random idle gap in between
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(op_e op, logic [TagW-1:0] tag, logic [StampW-1:0] stamp);
    pace();
    @(negedge clk);
    in_valid <= 1'b1;
    op_q     <= op;
    tag_q    <= tag;
    stamp_q  <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, tag, stamp);
    sent++;
  endtask

  // hold off until every owed result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    burst_left = 0;
  endtask

  // move the free-running tick count forward by a mix of small and large steps
  task automatic advance();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: now_ts = now_ts + $urandom_range(0, 200);
      6, 7:             now_ts = now_ts + $urandom_range(0, 1 << 20);
      8:                now_ts = now_ts + $urandom;
      default:          now_ts = now_ts + {$urandom, $urandom};
    endcase
  endtask

  function automatic logic [TagW-1:0] pick_tag();
    if (open_q.size() > 0 && $urandom_range(0, 1) == 0)
      return open_q[$urandom_range(0, open_q.size() - 1)];
    return pool[$urandom_range(0, 31)];
  endfunction

  initial begin
    int               pick;
    int               idx;
    int               fills;
    logic [TagW-1:0]  tag;
    sb     = new();
    fills  = 0;
    now_ts = {$urandom, $urandom};
    foreach (pool[i]) pool[i] = $urandom_range(0, 65535);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed: empty table, reruns, extremes, wrap, zero interval, clear
    send_item(OP_READ, 16'h0000, 48'h0);
    send_item(OP_END, 16'hFFFF, 48'h1);
    send_item(OP_BEGIN, 16'h0000, 48'h0);
    send_item(OP_BEGIN, 16'h0000, 48'h5);
    send_item(OP_END, 16'h0000, 48'hFFFF_FFFF_FFFF);
    send_item(OP_READ, 16'h0000, 48'h7);
    send_item(OP_END, 16'h0000, 48'h9);
    send_item(OP_BEGIN, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_item(OP_END, 16'hFFFF, 48'h3);
    send_item(OP_BEGIN, 16'hA5A5, 48'h5A5A_5A5A_5A5A);
    send_item(OP_END, 16'hA5A5, 48'h5A5A_5A5A_5A5A);
    send_item(OP_BEGIN, 16'hA5A5, 48'h0000_0000_0010);
    send_item(OP_END, 16'hA5A5, 48'h0000_0000_1010);
    send_item(OP_READ, 16'h5A5A, 48'hA5A5_A5A5_A5A5);
    send_item(OP_CLEAR, 16'h1234, 48'h0000_0000_0ABC);
    send_item(OP_READ, 16'h0000, 48'h0);
    send_item(OP_BEGIN, 16'h0000, 48'h100);
    send_item(OP_READ, 16'h0000, 48'h200);
    drain();

    // random: mostly interleaved begin/end pairs, some reads, noise and clears
    while (sent < ItemCount) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        tag = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                          : pool[$urandom_range(0, 31)];
        advance();
        send_item(OP_BEGIN, tag, now_ts);
        open_q.push_back(tag);
      end else if (pick < 75) begin
        if (open_q.size() > 0) begin
          idx = $urandom_range(0, open_q.size() - 1);
          tag = open_q[idx];
          open_q.delete(idx);
        end else begin
          tag = pool[$urandom_range(0, 31)];
        end
        advance();
        send_item(OP_END, tag, now_ts);
      end else if (pick < 83) begin
        send_item(OP_READ, pick_tag(), {$urandom, $urandom});
      end else if (pick < 95) begin
        tag = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535)) : pick_tag();
        send_item(op_e'($urandom_range(0, 3)), tag, {$urandom, $urandom});
      end else if (pick < 97) begin
        send_item(OP_CLEAR, 16'($urandom_range(0, 65535)), {$urandom, $urandom});
        open_q.delete();
      end else if (fills < 4) begin
        // push the table past its capacity with fresh tags
        fills++;
        repeat (70) begin
          advance();
          send_item(OP_BEGIN, 16'($urandom_range(0, 65535)), now_ts);
        end
      end else begin
        drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d transfers: %0d begin, %0d end, %0d read, %0d clear, %0d wrapped",
             sent, sb.n_op[OP_BEGIN], sb.n_op[OP_END], sb.n_op[OP_READ], sb.n_op[OP_CLEAR],
             sb.n_wrap);
    $display("status mix: ok %0d, running %0d, not found %0d, full %0d, not running %0d",
             sb.n_status[ST_OK], sb.n_status[ST_RUNNING], sb.n_status[ST_NOT_FOUND],
             sb.n_status[ST_FULL], sb.n_status[ST_NOT_RUNNING]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
